FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define PPDF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also holds across reset
`define PPDF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/ppdf_pkg.sv
// ----------------------------------------------------------------------------
// ppdf_pkg
// shared types, codes and widths of the point projection block
// ----------------------------------------------------------------------------
`default_nettype none

package ppdf_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int CW_EFF      = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  localparam int DW    = 33;          // camera offset
  localparam int MW    = 34;          // shared multiplier operand
  localparam int PW    = 2 * MW;      // shared multiplier product
  localparam int SUMW  = 66;          // sum of squares
  localparam int SQW   = 62;          // square root operand
  localparam int AXW   = 52;          // camera space axis
  localparam int QW    = 40;          // ratio quotient
  localparam int RSH   = QW - 12;
  localparam int FMW   = QW + 25;     // ratio times focal
  localparam int OFFW  = FMW - 16;    // rounded Q.4 offset
  localparam int SCW   = OFFW + 2;    // screen arithmetic

  localparam int SQRT_STEPS = SQW / 2;
  localparam int DIV_STEPS  = QW;
  localparam int LERP_STEPS = 8;

  localparam logic [SQW-1:0] SQRT_BIT0   = SQW'(1) << (SQW - 2);
  localparam logic [QW-1:0]  RATIO_LIMIT = QW'(1) << 38;
  localparam logic [FMW-1:0] ROUND_HALF  = FMW'(32768);

  // input commands
  localparam logic [1:0] CMD_POS  = 2'd0;
  localparam logic [1:0] CMD_ROT  = 2'd1;
  localparam logic [1:0] CMD_PROJ = 2'd2;

  // verdict codes
  localparam logic [1:0] VERDICT_DRAWN  = 2'd0;
  localparam logic [1:0] VERDICT_BEYOND = 2'd1;
  localparam logic [1:0] VERDICT_BEHIND = 2'd2;
  localparam logic [1:0] VERDICT_OFF    = 2'd3;

  // register indexes
  localparam logic [2:0] REG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_FOCAL_X = 3'd2;
  localparam logic [2:0] REG_FOCAL_Y = 3'd3;
  localparam logic [2:0] REG_MIRROR  = 3'd4;
  localparam logic [2:0] REG_MAX     = 3'd5;
  localparam logic [2:0] REG_NEAR    = 3'd6;
  localparam logic [2:0] REG_FAR     = 3'd7;

  // multiplier selects: three squares, max squared, then nine rotation terms
  localparam logic [3:0] MUL_MAXSQ = 4'd3;
  localparam int         MUL_ROT0  = 4;

  typedef struct packed {
    logic [11:0] width;
    logic [11:0] height;
    logic [23:0] focal_x;
    logic [23:0] focal_y;
    logic        mirror;
    logic [30:0] max_dist;
    logic [31:0] near;
    logic [31:0] far;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       start;
    logic       mul_en;
    logic [3:0] mul_sel;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       sel;
    logic       foc;
    logic       screen;
    logic       lerp_init;
    logic       lerp_step;
    logic       verdict_set;
    logic [1:0] verdict_code;
  } cmd_t;

  typedef struct packed {
    logic beyond;
    logic behind;
    logic offscreen;
  } status_t;

  function automatic logic signed [31:0] sext_coord(input logic [31:0] raw);
    logic [31:0] v;
    v = raw;
    for (int i = CW_EFF; i < 32; i++) begin
      v[i] = raw[CW_EFF-1];
    end
    return $signed(v);
  endfunction

endpackage

`default_nettype wire

FILE: design/point_project_distance_fade_core.sv
// ----------------------------------------------------------------------------
// point_project_distance_fade_core
// pinhole projection of world points with distance cull and colour fade
// ----------------------------------------------------------------------------
// Load items (command 0, 1) write the camera position or one rotation row in
// the cycle they are accepted and give no result. A project item (command 2)
// runs the multiplies (three squares, max squared, nine rotation terms),
// then a 31 step square root, two 40 step ratio divisions and an 8 step
// colour division. A point beyond range leaves after the range check, one
// behind the camera after the square root. One project item is in flight
// at a time, but the finished item sits in the output register so the next
// one may be accepted while it waits.
`default_nettype none

module point_project_distance_fade_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [1:0]  row_select,
  input  logic [31:0] coord_x,
  input  logic [31:0] coord_y,
  input  logic [31:0] coord_z,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  verdict,
  output logic [15:0] pixel_x,
  output logic [15:0] pixel_y,
  output logic [31:0] color_rgba
);
  import ppdf_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    in_ready_int;
  logic    out_load;
  logic    out_busy;
  logic [1:0]  res_verdict;
  logic [15:0] res_pixel_x, res_pixel_y;
  logic [31:0] res_color;

  // configuration registers, reset to the default camera setup
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width    <= 12'd2560;
      cfg.height   <= 12'd1440;
      cfg.focal_x  <= 24'd229443;
      cfg.focal_y  <= 24'd229443;
      cfg.mirror   <= 1'b1;
      cfg.max_dist <= 31'd655360;
      cfg.near     <= 32'hFF00FF00;
      cfg.far      <= 32'h400000FF;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WIDTH:   cfg.width    <= cfg_data[11:0];
        REG_HEIGHT:  cfg.height   <= cfg_data[11:0];
        REG_FOCAL_X: cfg.focal_x  <= cfg_data[23:0];
        REG_FOCAL_Y: cfg.focal_y  <= cfg_data[23:0];
        REG_MIRROR:  cfg.mirror   <= cfg_data[0];
        REG_MAX:     cfg.max_dist <= cfg_data[30:0];
        REG_NEAR:    cfg.near     <= cfg_data;
        REG_FAR:     cfg.far      <= cfg_data;
        default:     cfg.width    <= cfg.width;
      endcase
    end
  end

  assign in_ready = in_ready_int;
  // output register still holds an item nobody has taken
  assign out_busy = out_valid && !out_ready;

  ppdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .status   (status),
    .out_busy (out_busy),
    .in_ready (in_ready_int),
    .out_load (out_load),
    .cmd      (cmd)
  );

  ppdf_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .command     (command),
    .row_select  (row_select),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .status      (status),
    .res_verdict (res_verdict),
    .res_pixel_x (res_pixel_x),
    .res_pixel_y (res_pixel_y),
    .res_color   (res_color)
  );

  // output register, loaded only when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      verdict    <= res_verdict;
      pixel_x    <= res_pixel_x;
      pixel_y    <= res_pixel_y;
      color_rgba <= res_color;
    end
  end

endmodule

`default_nettype wire

FILE: design/ppdf_ctrl.sv
// ----------------------------------------------------------------------------
// ppdf_ctrl
// sequencer that steps the datapath through one projection
// ----------------------------------------------------------------------------
`default_nettype none

module ppdf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        command,
  input  ppdf_pkg::status_t status,
  input  logic              out_busy,
  output logic              in_ready,
  output logic              out_load,
  output ppdf_pkg::cmd_t    cmd
);
  import ppdf_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_ROT  = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_BEH  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_FOC  = 4'd7;
  localparam logic [3:0] S_SCR  = 4'd8;
  localparam logic [3:0] S_LERP = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0] state, state_next;
  logic [5:0] cnt, cnt_next;
  logic       pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pass  <= pass_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pass_next  = pass;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (command == CMD_PROJ) begin
            cmd.start  = 1'b1;
            cnt_next   = '0;
            state_next = S_SQ;
          end
        end
      end
      S_SQ: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = cnt[3:0];
        if (cnt[3:0] == MUL_MAXSQ) begin
          cnt_next   = '0;
          state_next = S_ROT;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_ROT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 4'(MUL_ROT0) + cnt[3:0];
        if (cnt == 6'd8) begin
          state_next = S_CHK;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_CHK: begin
        if (status.beyond) begin
          cmd.verdict_set  = 1'b1;
          cmd.verdict_code = VERDICT_BEYOND;
          state_next       = S_OUT;
        end else begin
          cmd.sqrt_init = 1'b1;
          cnt_next      = '0;
          state_next    = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt == 6'(SQRT_STEPS - 1)) begin
          state_next = S_BEH;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_BEH: begin
        if (status.behind) begin
          cmd.verdict_set  = 1'b1;
          cmd.verdict_code = VERDICT_BEHIND;
          state_next       = S_OUT;
        end else begin
          cmd.div_init = 1'b1;
          cmd.sel      = 1'b0;
          pass_next    = 1'b0;
          cnt_next     = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == 6'(DIV_STEPS - 1)) begin
          state_next = S_FOC;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_FOC: begin
        cmd.foc = 1'b1;
        cmd.sel = pass;
        if (!pass) begin
          cmd.div_init = 1'b1;
          pass_next    = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end else begin
          state_next = S_SCR;
        end
      end
      S_SCR: begin
        cmd.verdict_set = 1'b1;
        if (status.offscreen) begin
          cmd.verdict_code = VERDICT_OFF;
          state_next       = S_OUT;
        end else begin
          cmd.verdict_code = VERDICT_DRAWN;
          cmd.screen       = 1'b1;
          cmd.lerp_init    = 1'b1;
          cnt_next         = '0;
          state_next       = S_LERP;
        end
      end
      S_LERP: begin
        cmd.lerp_step = 1'b1;
        if (cnt == 6'(LERP_STEPS - 1)) begin
          state_next = S_OUT;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_OUT: begin
        if (!out_busy) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/ppdf_datapath.sv
// ----------------------------------------------------------------------------
// ppdf_datapath
// camera pose, shared multiplier, square root, ratio divider and colour lanes
// ----------------------------------------------------------------------------
`default_nettype none

module ppdf_datapath (
  input  logic              clk,
  input  logic              rst,
  input  ppdf_pkg::cfg_t    cfg,
  input  ppdf_pkg::cmd_t    cmd,
  input  logic [1:0]        command,
  input  logic [1:0]        row_select,
  input  logic [31:0]       coord_x,
  input  logic [31:0]       coord_y,
  input  logic [31:0]       coord_z,
  output ppdf_pkg::status_t status,
  output logic [1:0]        res_verdict,
  output logic [15:0]       res_pixel_x,
  output logic [15:0]       res_pixel_y,
  output logic [31:0]       res_color
);
  import ppdf_pkg::*;

  logic signed [31:0]   p [3];
  logic signed [31:0]   cam_pos [3];
  logic signed [31:0]   rot [9];
  logic signed [DW-1:0] d [3];

  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic [3:0]           prod_tag;
  logic                 prod_vld;
  logic [SUMW-1:0]      sum;
  logic [SQW-1:0]       mx2;
  logic signed [AXW-1:0] axis [3];

  logic [SQW-1:0] sx, sres, sbit, st;
  logic           sge;

  logic signed [AXW-1:0] num;
  logic [AXW-1:0]        mag;
  logic [AXW:0]          drem, drsh;
  logic [QW-1:0]         dq, qmag;
  logic                  dneg, dovf, dge;
  logic signed [QW-1:0]  ratio;
  logic signed [FMW-1:0] fm;
  logic signed [OFFW-1:0] off_x, off_y, off_new;

  logic signed [SCW-1:0] w8, h8, w16, h16, u4, v4;
  logic [15:0]           px, py;
  logic [1:0]            verdict;

  logic [30:0] eye_dist, mdiff;
  logic [31:0] ldiv;
  logic [32:0] lrem [4];
  logic [7:0]  lq [4];

  always_comb begin
    p[0] = sext_coord(coord_x);
    p[1] = sext_coord(coord_y);
    p[2] = sext_coord(coord_z);
  end

  // camera pose
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) cam_pos[i] <= '0;
      for (int i = 0; i < 9; i++) rot[i] <= '0;
    end else if (cmd.load) begin
      case (command)
        CMD_POS: begin
          for (int i = 0; i < 3; i++) cam_pos[i] <= p[i];
        end
        CMD_ROT: begin
          for (int r = 0; r < 3; r++) begin
            if (row_select == 2'(r)) begin
              for (int j = 0; j < 3; j++) rot[r*3+j] <= p[j];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 3; i++) begin
        d[i] <= DW'(p[i]) - DW'(cam_pos[i]);
      end
    end
  end

  // shared multiplier operand select
  always_comb begin
    ma = MW'(d[0]);
    mb = MW'(d[0]);
    for (int k = 0; k < 3; k++) begin
      if (cmd.mul_sel == 4'(k)) begin
        ma = MW'(d[k]);
        mb = MW'(d[k]);
      end
    end
    if (cmd.mul_sel == MUL_MAXSQ) begin
      ma = $signed(MW'(cfg.max_dist));
      mb = $signed(MW'(cfg.max_dist));
    end
    for (int e = 0; e < 9; e++) begin
      if (cmd.mul_sel == 4'(MUL_ROT0 + e)) begin
        ma = MW'(rot[e]);
        mb = MW'(d[e%3]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else if (cmd.start) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod     <= ma * mb;
      prod_tag <= cmd.mul_sel;
    end
  end

  // registered product is accumulated in the cycle after the multiply
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sum <= '0;
      for (int r = 0; r < 3; r++) axis[r] <= '0;
    end else if (prod_vld) begin
      if (prod_tag < MUL_MAXSQ) begin
        sum <= sum + prod[SUMW-1:0];
      end else if (prod_tag == MUL_MAXSQ) begin
        mx2 <= prod[SQW-1:0];
      end else begin
        for (int r = 0; r < 3; r++) begin
          if (prod_tag >= 4'(MUL_ROT0 + 3*r) && prod_tag < 4'(MUL_ROT0 + 3*r + 3)) begin
            axis[r] <= axis[r] + $signed(prod[AXW+15:16]);
          end
        end
      end
    end
  end

  // square root, one result bit a step
  always_comb begin
    st  = sres + sbit;
    sge = (sx >= st);
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sx   <= sum[SQW-1:0];
      sres <= '0;
      sbit <= SQRT_BIT0;
    end else if (cmd.sqrt_step) begin
      sx   <= sge ? (sx - st) : sx;
      sres <= sge ? ((sres >> 1) + sbit) : (sres >> 1);
      sbit <= sbit >> 2;
    end
  end

  assign eye_dist = sres[30:0];

  // ratio divider: |num| * 4096 / depth, one quotient bit a step
  // the up ratio is loaded while the side offset is being stored
  always_comb begin
    num  = (cmd.sel || cmd.foc) ? axis[2] : axis[1];
    mag  = num[AXW-1] ? AXW'(-num) : AXW'(num);
    drsh = {drem[AXW-1:0], dq[QW-1]};
    dge  = (drsh >= {1'b0, axis[0]});
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dneg <= num[AXW-1];
      dovf <= ((mag >> RSH) >= AXW'(axis[0]));
      drem <= (AXW+1)'(mag >> RSH);
      dq   <= {mag[RSH-1:0], 12'b0};
    end else if (cmd.div_step) begin
      drem <= dge ? (drsh - {1'b0, axis[0]}) : drsh;
      dq   <= {dq[QW-2:0], dge};
    end
  end

  // clamp, sign and focal scale rounded to Q.4
  always_comb begin
    qmag    = (dovf || dq > RATIO_LIMIT) ? RATIO_LIMIT : dq;
    ratio   = dneg ? -$signed(qmag) : $signed(qmag);
    fm      = FMW'(ratio) * $signed({1'b0, (cmd.sel ? cfg.focal_y : cfg.focal_x)});
    fm      = fm + $signed(ROUND_HALF);
    off_new = fm[FMW-1:16];
  end

  always_ff @(posedge clk) begin
    if (cmd.foc) begin
      if (cmd.sel) off_y <= off_new;
      else         off_x <= off_new;
    end
  end

  // screen position and bounds
  always_comb begin
    w8  = $signed(SCW'({cfg.width, 3'b0}));
    h8  = $signed(SCW'({cfg.height, 3'b0}));
    w16 = $signed(SCW'({cfg.width, 4'b0}));
    h16 = $signed(SCW'({cfg.height, 4'b0}));
    u4  = cfg.mirror ? (w8 - SCW'(off_x)) : (w8 + SCW'(off_x));
    v4  = h8 - SCW'(off_y);
    status.offscreen = (u4 < 0) || (u4 > w16) || (v4 < 0) || (v4 > h16);
    status.beyond    = (sum > SUMW'(mx2));
    status.behind    = (axis[0] <= 0);
  end

  always_ff @(posedge clk) begin
    if (cmd.screen) begin
      px <= u4[15:0];
      py <= v4[15:0];
    end
    if (cmd.verdict_set) begin
      verdict <= cmd.verdict_code;
    end
  end

  // colour lanes: (2*num + max) / (2*max), eight quotient bits
  assign mdiff = cfg.max_dist - eye_dist;
  assign ldiv  = {cfg.max_dist, 1'b0};

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 4; ch++) begin
      logic [39:0] lnum;
      logic [41:0] ln2;
      logic [32:0] lsh;
      lnum = 40'(cfg.near[8*ch +: 8]) * 40'(mdiff) + 40'(cfg.far[8*ch +: 8]) * 40'(eye_dist);
      ln2  = {1'b0, lnum, 1'b0} + 42'(cfg.max_dist);
      lsh  = {lrem[ch][31:0], lq[ch][7]};
      if (cmd.lerp_init) begin
        lrem[ch] <= ln2[40:8];
        lq[ch]   <= ln2[7:0];
      end else if (cmd.lerp_step) begin
        lrem[ch] <= (lsh >= {1'b0, ldiv}) ? (lsh - {1'b0, ldiv}) : lsh;
        lq[ch]   <= {lq[ch][6:0], (lsh >= {1'b0, ldiv})};
      end
    end
  end

  always_comb begin
    res_verdict = verdict;
    res_pixel_x = '0;
    res_pixel_y = '0;
    res_color   = '0;
    if (verdict == VERDICT_DRAWN) begin
      res_pixel_x = px;
      res_pixel_y = py;
      res_color   = (cfg.max_dist == '0) ? cfg.near : {lq[3], lq[2], lq[1], lq[0]};
    end
  end

endmodule

`default_nettype wire

FILE: design/ppdf_checker.sv
// ----------------------------------------------------------------------------
// ppdf_checker
// port level checks on the result channel of the projection block
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ppdf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  verdict,
  input logic [15:0] pixel_x,
  input logic [15:0] pixel_y,
  input logic [31:0] color_rgba
);
  import ppdf_pkg::*;

  `PPDF_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result valid after reset")
  `PPDF_ASSERT(a_hold_valid, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")
  `PPDF_ASSERT(a_zero_fields, clk, rst, out_valid && verdict != VERDICT_DRAWN |-> pixel_x == 16'd0 && pixel_y == 16'd0 && color_rgba == 32'd0, "rejected item has data")
  `PPDF_ASSERT(a_drawn_stable, clk, rst, out_valid && !out_ready && verdict == VERDICT_DRAWN |=> verdict == VERDICT_DRAWN, "drawn verdict changed")

endmodule

bind point_project_distance_fade_core ppdf_checker u_ppdf_checker (.*);

`default_nettype wire

FILE: test/tb_point_project_distance_fade_core.sv
// ----------------------------------------------------------------------------
// tb_point_project_distance_fade_core
// self-checking bench for the point projection and distance fade block
// ----------------------------------------------------------------------------
// Drives load and project items through the valid/ready input channel, works
// out each expected result with an internal predictor that tracks the camera
// pose and configuration, and checks each result item field by field against
// the oldest expected one. Configuration is rewritten between phases once the
// block has drained.
`default_nettype none

class projection_scoreboard;
  typedef struct {
    logic [1:0]  verdict;
    logic [15:0] px;
    logic [15:0] py;
    logic [31:0] rgba;
  } proj_result_t;

  logic [11:0] width;
  logic [11:0] height;
  logic [23:0] focal_x;
  logic [23:0] focal_y;
  logic        mirror;
  logic [30:0] max_dist;
  logic [31:0] near;
  logic [31:0] far;
  longint      cam_pos[3];
  longint      cam_rot[9];
  proj_result_t pending[$];
  int          errors;

  function new();
    width = 12'd2560;
    height = 12'd1440;
    focal_x = 24'd229443;
    focal_y = 24'd229443;
    mirror = 1'b1;
    max_dist = 31'd655360;
    near = 32'd4278255360;
    far = 32'd1073742079;
    foreach (cam_pos[i]) cam_pos[i] = 0;
    foreach (cam_rot[i]) cam_rot[i] = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      ppdf_pkg::REG_WIDTH:   width = val[11:0];
      ppdf_pkg::REG_HEIGHT:  height = val[11:0];
      ppdf_pkg::REG_FOCAL_X: focal_x = val[23:0];
      ppdf_pkg::REG_FOCAL_Y: focal_y = val[23:0];
      ppdf_pkg::REG_MIRROR:  mirror = val[0];
      ppdf_pkg::REG_MAX:     max_dist = val[30:0];
      ppdf_pkg::REG_NEAR:    near = val;
      ppdf_pkg::REG_FAR:     far = val;
      default: ;
    endcase
  endfunction

  // floor of an arithmetic shift
  function longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function longint camera_axis(int row, longint d[3]);
    longint acc;
    acc = 0;
    for (int j = 0; j < 3; j++) acc += floor_shr(cam_rot[row*3+j] * d[j], 16);
    return acc;
  endfunction

  function longint focal_offset(longint num, longint depth, logic [23:0] f);
    longint r;
    r = (num * 4096) / depth;
    if (r > (64'sd1 <<< 38)) r = 64'sd1 <<< 38;
    if (r < -(64'sd1 <<< 38)) r = -(64'sd1 <<< 38);
    return floor_shr(r * longint'(f) + 32768, 16);
  endfunction

  function logic [31:0] faded_colour(longint unsigned eye_dist);
    logic [31:0] o;
    longint n, fc, m, num, c;
    if (max_dist == 0) return near;
    o = 0;
    m = longint'(max_dist);
    for (int ch = 0; ch < 4; ch++) begin
      n = longint'(near[8*ch +: 8]);
      fc = longint'(far[8*ch +: 8]);
      num = n * m + (fc - n) * longint'(eye_dist);
      c = (2 * num + m) / (2 * m);
      if (c < 0) c = 0;
      if (c > 255) c = 255;
      o[8*ch +: 8] = c[7:0];
    end
    return o;
  endfunction

  // notes one accepted input item and queues its expected result
  function void note_input(logic [1:0] cmd, logic [1:0] row, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z);
    longint p[3], d[3];
    longint unsigned lo, sq, a, mx2, eye_dist;
    int carry;
    longint cx, cy, cz, ox, oy, u4, v4;
    proj_result_t r;
    p[0] = longint'(ppdf_pkg::sext_coord(x));
    p[1] = longint'(ppdf_pkg::sext_coord(y));
    p[2] = longint'(ppdf_pkg::sext_coord(z));
    if (cmd == ppdf_pkg::CMD_POS) begin
      foreach (p[i]) cam_pos[i] = p[i];
      return;
    end
    if (cmd == ppdf_pkg::CMD_ROT) begin
      if (row < 3) for (int i = 0; i < 3; i++) cam_rot[row*3+i] = p[i];
      return;
    end
    if (cmd != ppdf_pkg::CMD_PROJ) return;
    r = '{ppdf_pkg::VERDICT_DRAWN, 16'd0, 16'd0, 32'd0};
    lo = 0;
    carry = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = p[i] - cam_pos[i];
      a = d[i] < 0 ? longint'(-d[i]) : longint'(d[i]);
      sq = a * a;
      lo = lo + sq;
      if (lo < sq) carry++;
    end
    mx2 = longint'(max_dist) * longint'(max_dist);
    if (carry != 0 || lo > mx2) begin
      r.verdict = ppdf_pkg::VERDICT_BEYOND;
      pending.push_back(r);
      return;
    end
    eye_dist = int_sqrt(lo);
    cx = camera_axis(0, d);
    if (cx <= 0) begin
      r.verdict = ppdf_pkg::VERDICT_BEHIND;
      pending.push_back(r);
      return;
    end
    cy = camera_axis(1, d);
    cz = camera_axis(2, d);
    ox = focal_offset(cy, cx, focal_x);
    oy = focal_offset(cz, cx, focal_y);
    u4 = longint'(width) * 8 + (mirror ? -ox : ox);
    v4 = longint'(height) * 8 - oy;
    if (u4 < 0 || u4 > longint'(width) * 16 || v4 < 0 || v4 > longint'(height) * 16) begin
      r.verdict = ppdf_pkg::VERDICT_OFF;
      pending.push_back(r);
      return;
    end
    r.px = u4 > 65535 ? 16'hFFFF : u4[15:0];
    r.py = v4 > 65535 ? 16'hFFFF : v4[15:0];
    r.rgba = faded_colour(eye_dist);
    pending.push_back(r);
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task check_result(logic [1:0] v, logic [15:0] px, logic [15:0] py,
                    logic [31:0] c);
    proj_result_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result verdict %0d", v));
      return;
    end
    e = pending.pop_front();
    if (v !== e.verdict) report($sformatf("verdict %0d, want %0d", v, e.verdict));
    if (px !== e.px) report($sformatf("pixel_x %0h, want %0h", px, e.px));
    if (py !== e.py) report($sformatf("pixel_y %0h, want %0h", py, e.py));
    if (c !== e.rgba) report($sformatf("colour %08h, want %08h", c, e.rgba));
  endtask
endclass

module tb_point_project_distance_fade_core;
  import ppdf_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [1:0]  row_select;
  logic [31:0] coord_x;
  logic [31:0] coord_y;
  logic [31:0] coord_z;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  verdict;
  logic [15:0] pixel_x;
  logic [15:0] pixel_y;
  logic [31:0] color_rgba;

  projection_scoreboard board;
  bit   idle_free;      // stretch with no idling on either side
  int   hold_cycles;    // long receiver hold-off, counted in its own process

  point_project_distance_fade_core DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .row_select(row_select),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .verdict(verdict), .pixel_x(pixel_x), .pixel_y(pixel_y), .color_rgba(color_rgba)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous fixed limit: ~2000 items, plus stalls
  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls, one long hold-off, check on every accepted item
  initial begin
    out_ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        board.check_result(verdict, pixel_x, pixel_y, color_rgba);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= idle_free || ($urandom_range(99) >= 28);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.write_reg(idx, val);
    @(posedge clk);
  endtask

  // offer one item, holding it until accepted; random gaps before it
  task automatic send_item(logic [1:0] cmd, logic [1:0] row, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z);
    while (!idle_free && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    row_select <= row;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(cmd, row, x, y, z);
  endtask

  // wait for the block to drain, then the project latency before reconfiguring
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= 200000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    repeat (300) @(posedge clk);
  endtask

  // signed Q16.16 value of modest size, or any value now and then
  function automatic logic [31:0] coord_value(int span);
    if ($urandom_range(15) == 0) return $urandom;
    return 32'($signed($urandom_range(2 * span)) - span);
  endfunction

  // random camera position, then forward, side and up rows: identity, a quarter turn or random rows
  task automatic load_camera();
    logic [31:0] one;
    int pick;
    one = 32'h0001_0000;
    pick = $urandom_range(3);
    send_item(CMD_POS, 2'd0, coord_value(3 << 16), coord_value(3 << 16),
              coord_value(3 << 16));
    case (pick)
      0: begin
        send_item(CMD_ROT, 2'd0, one, 0, 0);
        send_item(CMD_ROT, 2'd1, 0, one, 0);
        send_item(CMD_ROT, 2'd2, 0, 0, one);
      end
      1: begin
        send_item(CMD_ROT, 2'd0, 0, one, 0);
        send_item(CMD_ROT, 2'd1, -one, 0, 0);
        send_item(CMD_ROT, 2'd2, 0, 0, one);
      end
      default: begin
        for (int r = 0; r < 3; r++)
          send_item(CMD_ROT, 2'(r), coord_value(1 << 16), coord_value(1 << 16),
                    coord_value(1 << 16));
      end
    endcase
  endtask

  // random project points around the camera, with some camera loads and random items among them
  task automatic random_phase(int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 4) load_camera();
      else if (kind < 7)
        send_item(2'($urandom_range(3)), 2'($urandom_range(3)), $urandom, $urandom,
                  $urandom);
      else
        send_item(CMD_PROJ, 2'($urandom_range(3)),
                  32'(board.cam_pos[0] + coord_value(12 << 16)),
                  32'(board.cam_pos[1] + coord_value(4 << 16)),
                  32'(board.cam_pos[2] + coord_value(4 << 16)));
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    command = '0;
    row_select = '0;
    coord_x = '0;
    coord_y = '0;
    coord_z = '0;
    idle_free = 1'b0;
    hold_cycles = 0;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: camera identity, then points in front, behind, at camera, far
    send_item(CMD_PROJ, 2'd0, 0, 0, 0);                       // zero pose: behind
    send_item(CMD_ROT, 2'd0, 32'h0001_0000, 0, 0);
    send_item(CMD_ROT, 2'd1, 0, 32'h0001_0000, 0);
    send_item(CMD_ROT, 2'd2, 0, 0, 32'h0001_0000);
    send_item(CMD_ROT, 2'd3, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF); // unused row
    send_item(2'd3, 2'd0, 32'h1234_5678, 0, 0);               // unused command
    send_item(CMD_PROJ, 2'd0, 32'h0005_0000, 0, 0);           // straight ahead
    send_item(CMD_PROJ, 2'd0, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
    send_item(CMD_PROJ, 2'd0, 32'hFFFB_0000, 0, 0);           // behind
    send_item(CMD_PROJ, 2'd0, 32'h000A_0000, 0, 0);           // exactly at max
    send_item(CMD_PROJ, 2'd0, 32'h000A_0001, 0, 0);           // just beyond
    send_item(CMD_PROJ, 2'd0, 32'h0000_0001, 32'h0009_0000, 0); // off screen
    send_item(CMD_PROJ, 2'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_PROJ, 2'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(CMD_POS, 2'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_PROJ, 2'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF); // at camera
    send_item(CMD_POS, 2'd0, 0, 0, 0);
    drain();

    // extremes of the registers, zero max distance among them
    write_reg(REG_MAX, 32'd0);
    write_reg(REG_WIDTH, 32'd1);
    write_reg(REG_HEIGHT, 32'd4095);
    write_reg(REG_MIRROR, 32'd0);
    send_item(CMD_PROJ, 2'd0, 0, 0, 0);
    send_item(CMD_PROJ, 2'd0, 32'h0000_0001, 0, 0);
    drain();
    write_reg(REG_MAX, 32'h7FFF_FFFF);
    write_reg(REG_FOCAL_X, 32'hFFFF_FFFF);
    write_reg(REG_FOCAL_Y, 32'd0);
    write_reg(REG_NEAR, 32'h0000_0000);
    write_reg(REG_FAR, 32'hFFFF_FFFF);
    send_item(CMD_PROJ, 2'd0, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000);
    send_item(CMD_PROJ, 2'd0, 32'h0100_0000, 32'hFFFF_FFFF, 0);
    drain();

    // random phases, each with its own settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_WIDTH, ph == 0 ? 32'd4095 : $urandom_range(1, 4095));
      write_reg(REG_HEIGHT, ph == 1 ? 32'd1 : $urandom_range(1, 4095));
      write_reg(REG_FOCAL_X, ph == 2 ? 32'hFF_FFFF : $urandom_range(0, 600000));
      write_reg(REG_FOCAL_Y, ph == 3 ? 32'd0 : $urandom_range(0, 600000));
      write_reg(REG_MIRROR, $urandom_range(1));
      write_reg(REG_MAX, ph == 4 ? 32'h7FFF_FFFF : $urandom_range(65536, 20 << 16));
      write_reg(REG_NEAR, $urandom);
      write_reg(REG_FAR, $urandom);
      load_camera();
      if (ph == 2) begin
        // back-pressure: sender keeps offering while the receiver holds off
        hold_cycles = 2000;
        idle_free = 1'b1;
      end
      if (ph == 3) idle_free = 1'b1;
      random_phase(300);
      idle_free = 1'b0;
      drain();
    end

    if (board.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

`default_nettype wire

FILE: sim.f
+incdir+design
design/ppdf_pkg.sv
design/ppdf_ctrl.sv
design/ppdf_datapath.sv
design/point_project_distance_fade_core.sv
design/ppdf_checker.sv
test/tb_point_project_distance_fade_core.sv
